// ----- src/ito_pkg.sv -----
package ito_pkg;

    localparam int VAL_W  = 64;
    localparam int BCD_W  = 80;
    localparam int CNT_W  = 7;
    localparam int CHAR_W = 7;
    localparam int DIG_W  = 4;
    localparam int NDIG_DEC = BCD_W / DIG_W;

    localparam logic [CNT_W-1:0] NUM_DEC  = CNT_W'(NDIG_DEC);
    localparam logic [CNT_W-1:0] NUM_HEX  = CNT_W'(VAL_W / DIG_W);
    localparam logic [CNT_W-1:0] NUM_BIN  = CNT_W'(VAL_W);
    localparam logic [CNT_W-1:0] NUM_BITS = CNT_W'(VAL_W);

    localparam logic [CHAR_W-1:0] CHAR_MINUS    = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_HEX_BASE = 7'h37;

    typedef enum logic [1:0] {
        KIND_UDEC = 2'd0,
        KIND_SDEC = 2'd1,
        KIND_HEX  = 2'd2,
        KIND_BIN  = 2'd3
    } kind_t;

    // command from the sequencer to the character emitter
    typedef struct packed {
        logic             start;
        logic [BCD_W-1:0] data;   // digits left-aligned, most significant first
        logic [CNT_W-1:0] count;  // number of digit positions in data
        logic             bin;    // 1-bit digits instead of 4-bit digits
        logic             neg;    // prefix a minus sign
    } emit_cmd_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIG_W){1'b0}}, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + ext;
        end else begin
            return CHAR_HEX_BASE + ext;
        end
    endfunction

endpackage

// ----- src/ito_dabble.sv -----
module ito_dabble (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ito_pkg::VAL_W-1:0]   value,
    output logic                        busy,
    output logic [ito_pkg::BCD_W-1:0]   bcd
);

    logic [ito_pkg::VAL_W-1:0] bin_reg, bin_next;
    logic [ito_pkg::BCD_W-1:0] bcd_reg, bcd_next;
    logic [ito_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [ito_pkg::BCD_W-1:0] adj;

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        logic [ito_pkg::DIG_W-1:0] dig;
        for (int i = 0; i < ito_pkg::NDIG_DEC; i++) begin
            dig = bcd_reg[i*ito_pkg::DIG_W +: ito_pkg::DIG_W];
            adj[i*ito_pkg::DIG_W +: ito_pkg::DIG_W] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    always_comb begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        if (start) begin
            bin_next = value;
            bcd_next = '0;
            cnt_next = ito_pkg::NUM_BITS;
        end else if (cnt_reg != '0) begin
            bcd_next = {adj[ito_pkg::BCD_W-2:0], bin_reg[ito_pkg::VAL_W-1]};
            bin_next = {bin_reg[ito_pkg::VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = (cnt_reg != '0);
    assign bcd  = bcd_reg;

`ifndef SYNTHESIS
    a_dabble_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) && !start |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("dabble counter did not advance by one");
`endif

endmodule

// ----- src/ito_emit.sv -----
module ito_emit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ito_pkg::emit_cmd_t    cmd,
    output logic                  busy,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,  // [6:0] char_out, [7] zero
    output logic                  m_tlast   // last
);

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_SKIP  = 4'b0010,
        E_SIGN  = 4'b0100,
        E_DIGIT = 4'b1000
    } estate_t;

    estate_t                          state_reg, state_next;
    logic [ito_pkg::BCD_W-1:0]        data_reg, data_next;
    logic [ito_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                             bin_reg, bin_next;
    logic                             neg_reg, neg_next;
    logic                             out_valid_reg, out_valid_next;
    logic [ito_pkg::CHAR_W-1:0]       out_char_reg, out_char_next;
    logic                             out_last_reg, out_last_next;

    logic [ito_pkg::DIG_W-1:0]        top_dig;
    logic [ito_pkg::BCD_W-1:0]        shifted;
    logic                             slot_free;

    assign top_dig = bin_reg ? {3'b000, data_reg[ito_pkg::BCD_W-1]}
                             : data_reg[ito_pkg::BCD_W-1 -: ito_pkg::DIG_W];
    assign shifted = bin_reg ? {data_reg[ito_pkg::BCD_W-2:0], 1'b0}
                             : {data_reg[ito_pkg::BCD_W-ito_pkg::DIG_W-1:0],
                                {ito_pkg::DIG_W{1'b0}}};
    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        data_next      = data_reg;
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            E_IDLE: begin
                if (cmd.start) begin
                    data_next  = cmd.data;
                    cnt_next   = cmd.count;
                    bin_next   = cmd.bin;
                    neg_next   = cmd.neg;
                    state_next = E_SKIP;
                end
            end
            E_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (top_dig == '0 && cnt_reg != 7'd1) begin
                    data_next = shifted;
                    cnt_next  = cnt_reg - 1'b1;
                end else begin
                    state_next = neg_reg ? E_SIGN : E_DIGIT;
                end
            end
            E_SIGN: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ito_pkg::CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = E_DIGIT;
                end
            end
            E_DIGIT: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ito_pkg::digit_char(top_dig);
                    out_last_next  = (cnt_reg == 7'd1);
                    data_next      = shifted;
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg == 7'd1) begin
                        state_next = E_IDLE;
                    end
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= E_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        data_reg     <= data_next;
        cnt_reg      <= cnt_next;
        bin_reg      <= bin_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign busy     = (state_reg != E_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == E_DIGIT |-> cnt_reg != '0)
        else $error("emitting a digit with no digits left");
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_char_reg == ito_pkg::CHAR_MINUS |-> !out_last_reg)
        else $error("minus sign flagged as last word");
`endif

endmodule

// ----- src/integer_to_ascii_formatter.sv -----
// Decimal values go through the shift-add-3 (double dabble) unit and then the emitter;
// hex and binary values go straight to the emitter. The emitter skips leading zero digits,
// keeps at least one, and prefixes a minus sign for a negative signed decimal value.
// Throughput: one item at a time; a new item is accepted only once the emitter has queued
// the last word of the previous item, and each word can wait on m_tready.
// Reset (aresetn low, synchronous) returns the sequencer to idle and empties the output.
module integer_to_ascii_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_out, [7] zero
    output logic        m_tlast    // last
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DABBLE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic                       neg_reg, neg_next;
    ito_pkg::kind_t             kind;
    logic                       accept;
    logic                       neg_in;
    logic [ito_pkg::VAL_W-1:0]  mag;
    logic                       dab_start;
    logic                       dab_busy;
    logic [ito_pkg::BCD_W-1:0]  dab_bcd;
    ito_pkg::emit_cmd_t         cmd;
    logic                       emit_busy;

    assign kind     = ito_pkg::kind_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign neg_in   = (kind == ito_pkg::KIND_SDEC) && s_tdata[ito_pkg::VAL_W-1];
    assign mag      = neg_in ? (~s_tdata + 1'b1) : s_tdata;

    always_comb begin
        state_next = state_reg;
        neg_next   = neg_reg;
        dab_start  = 1'b0;
        cmd.start  = 1'b0;
        cmd.data   = {s_tdata, {(ito_pkg::BCD_W-ito_pkg::VAL_W){1'b0}}};
        cmd.count  = ito_pkg::NUM_HEX;
        cmd.bin    = 1'b0;
        cmd.neg    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (kind inside {ito_pkg::KIND_UDEC, ito_pkg::KIND_SDEC}) begin
                        dab_start  = 1'b1;
                        neg_next   = neg_in;
                        state_next = ST_DABBLE;
                    end else begin
                        cmd.start  = 1'b1;
                        cmd.bin    = (kind == ito_pkg::KIND_BIN);
                        cmd.count  = (kind == ito_pkg::KIND_BIN) ? ito_pkg::NUM_BIN
                                                                 : ito_pkg::NUM_HEX;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DABBLE: begin
                if (!dab_busy) begin
                    cmd.start  = 1'b1;
                    cmd.data   = dab_bcd;
                    cmd.count  = ito_pkg::NUM_DEC;
                    cmd.neg    = neg_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!emit_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        neg_reg <= neg_next;
    end

    ito_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dab_start),
        .value   (mag),
        .busy    (dab_busy),
        .bcd     (dab_bcd)
    );

    ito_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_idle_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE || state_reg == ST_DABBLE |-> !emit_busy)
        else $error("emitter busy while sequencer does not own it");
`endif

endmodule
